/* hdl/mbds_pkg.sv */
package mbds_pkg;

    localparam int FRAC = 30;
    localparam longint unsigned FX_ONE = 64'd1 << FRAC;
    localparam longint unsigned ENC_LOW_DIV = 64'd10 * FX_ONE;
    localparam longint unsigned ENC_HIGH_DIV = 64'd1000 * FX_ONE;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int WIDTH_REG_W = 13;
    localparam int HEIGHT_REG_W = 16;
    localparam int SUM_SMALL_W = 12;
    localparam int COUNT_W = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SRGB_MODE = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_WEIGHTED = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } texel_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       last_texel;
    } mip_texel_t;

    typedef struct packed {
        logic [WIDTH_REG_W-1:0]  src_width;
        logic [HEIGHT_REG_W-1:0] src_height;
        logic                    srgb_mode;
        logic                    alpha_weighted;
    } cfg_t;

    function automatic longint unsigned fx_pow(longint unsigned r, int n);
        longint unsigned p;
        int i;
        p = FX_ONE;
        for (i = 0; i < n; i++)
        begin
            p = (p * r) >> FRAC;
        end
        return p;
    endfunction

    function automatic longint unsigned fx_root(longint unsigned v, int n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 64'd0;
        hi = FX_ONE;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 64'd1) / 64'd2;
            if (fx_pow(mid, n) <= v)
                lo = mid;
            else
                hi = mid - 64'd1;
        end
        return lo;
    endfunction

    // sRGB byte to unsigned linear fraction of lb bits
    function automatic longint unsigned decode_entry(int c, int lb);
        longint unsigned cc;
        longint unsigned r;
        longint unsigned t;
        longint unsigned v;
        longint unsigned lin;
        longint unsigned lmax;
        cc = longint'(c);
        lmax = (64'd1 << lb) - 64'd1;
        if (cc <= 64'd10)
        begin
            r = (((cc * 64'd20) << lb) + 64'd32946) / 64'd65892;
        end
        else
        begin
            t = ((64'd1000 * cc + 64'd14025) << FRAC) / 64'd269025;
            v = (t * t) >> FRAC;
            lin = (v * fx_root(v, 5)) >> FRAC;
            r = (lin + (64'd1 << (FRAC - 1 - lb))) >> (FRAC - lb);
        end
        return (r > lmax) ? lmax : r;
    endfunction

    // linear bin midpoint to sRGB byte
    function automatic longint unsigned encode_entry(int i, int eb);
        longint unsigned x;
        longint unsigned b;
        longint unsigned c;
        longint unsigned p;
        longint unsigned num;
        longint unsigned off;
        x = (64'd2 * longint'(i) + 64'd1) << (FRAC - 1 - eb);
        if (x * 64'd10000000 <= 64'd31308 * FX_ONE)
        begin
            b = (x * 64'd32946 + 64'd5 * FX_ONE) / ENC_LOW_DIV;
        end
        else
        begin
            c = fx_root(x, 3);
            p = (c * fx_root(c, 4)) >> FRAC;
            num = 64'd269025 * p;
            off = 64'd14025 * FX_ONE;
            b = (num <= off) ? 64'd0 : (num - off + 64'd500 * FX_ONE) / ENC_HIGH_DIV;
        end
        return (b > 64'd255) ? 64'd255 : b;
    endfunction

endpackage

/* hdl/mbds_ram.sv */
module mbds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/mbds_enc_rom.sv */
module mbds_enc_rom #(
    parameter int ENCODE_INDEX_BITS = 12
) (
    input  logic                         clk,
    input  logic [ENCODE_INDEX_BITS-1:0] addr,
    output logic [7:0]                   data
);

    localparam int DEPTH = 1 << ENCODE_INDEX_BITS;

    logic [7:0] lut [DEPTH];

    for (genvar gi = 0; gi < DEPTH; gi++)
    begin : g_lut
        assign lut[gi] = 8'(mbds_pkg::encode_entry(gi, ENCODE_INDEX_BITS));
    end

    always_ff @(posedge clk)
    begin
        data <= lut[addr];
    end

endmodule

/* hdl/mbds_queue.sv */
module mbds_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop = pop && !empty;
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* hdl/mbds_front.sv */
module mbds_front #(
    parameter int MAX_SRC_WIDTH = 4096,
    parameter int LINEAR_BITS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  mbds_pkg::cfg_t                              cfg,
    input  logic                                        restart,
    input  logic                                        texel_valid,
    output logic                                        texel_stall,
    input  mbds_pkg::texel_t                            texel,
    output logic                                        q_push,
    output logic [3*(LINEAR_BITS+12)+2*mbds_pkg::SUM_SMALL_W+mbds_pkg::COUNT_W:0] q_data,
    input  logic                                        q_full
);

    localparam int HALF = MAX_SRC_WIDTH / 2;
    localparam int AW = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int EW = $clog2(MAX_SRC_WIDTH + 1);
    localparam int PW = $clog2(MAX_SRC_WIDTH);
    localparam int WCMP = (EW > mbds_pkg::WIDTH_REG_W) ? EW : mbds_pkg::WIDTH_REG_W;
    localparam int HW = mbds_pkg::HEIGHT_REG_W;
    localparam int CH_W = LINEAR_BITS + 8;
    localparam int SUM_W = LINEAR_BITS + 12;
    localparam int SW = mbds_pkg::SUM_SMALL_W;
    localparam int NW_W = mbds_pkg::COUNT_W;
    localparam int RAM_W = 3 * SUM_W + 2 * SW;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_ACC = 1'b1;

    logic [LINEAR_BITS-1:0] dec_lut [256];

    for (genvar gi = 0; gi < 256; gi++)
    begin : g_dec
        assign dec_lut[gi] = LINEAR_BITS'(mbds_pkg::decode_entry(gi, LINEAR_BITS));
    end

    logic            state_reg;
    logic            state_next;
    logic [PW-1:0]   col_reg;
    logic [PW-1:0]   col_next;
    logic [HW-1:0]   row_reg;
    logic [HW-1:0]   row_next;
    logic [1:0]      win_reg;
    logic [1:0]      win_next;

    logic [CH_W-1:0] ch_reg [3];
    logic [7:0]      wt_reg;
    logic [7:0]      alpha_reg;
    logic            clear_reg;
    logic            emit_reg;
    logic [NW_W-1:0] n_reg;
    logic            last_reg;
    logic [AW-1:0]   ox_reg;

    logic [WCMP-1:0] w_raw;
    logic [EW-1:0]   w_eff;
    logic [HW-1:0]   h_eff;
    logic [EW-1:0]   nw;
    logic [HW-1:0]   nh;
    logic [EW-1:0]   sx;
    logic [HW-1:0]   sy;
    logic [EW-1:0]   sxh;
    logic [HW-1:0]   syh;
    logic [EW-1:0]   oxf;
    logic [HW-1:0]   oyf;
    logic [AW-1:0]   ox;
    logic            first_col;
    logic            last_col;
    logic            last_row;
    logic            w_last;
    logic            h_last;
    logic [1:0]      gw;
    logic [1:0]      gh;
    logic [NW_W-1:0] n_cnt;
    logic            accept;
    logic            proceed;
    logic [7:0]      wt;
    logic [LINEAR_BITS-1:0] val [3];
    logic [7:0]      bytes [3];

    logic [RAM_W-1:0] ram_rdata;
    logic [RAM_W-1:0] ram_wdata;
    logic [AW-1:0]    ram_raddr;
    logic             ram_we;
    logic [SUM_W-1:0] old_sum [3];
    logic [SUM_W-1:0] new_sum [3];
    logic [SW-1:0]    old_ws;
    logic [SW-1:0]    old_as;
    logic [SW-1:0]    new_ws;
    logic [SW-1:0]    new_as;

    assign w_raw = WCMP'(cfg.src_width);

    always_comb
    begin
        if (w_raw == '0)
            w_eff = EW'(1);
        else if (w_raw > WCMP'(MAX_SRC_WIDTH))
            w_eff = EW'(MAX_SRC_WIDTH);
        else
            w_eff = EW'(w_raw);
        h_eff = (cfg.src_height == '0) ? HW'(1) : cfg.src_height;
        nw = ((w_eff >> 1) == '0) ? EW'(1) : (w_eff >> 1);
        nh = ((h_eff >> 1) == '0) ? HW'(1) : (h_eff >> 1);
        sx = (EW'(col_reg) < w_eff) ? EW'(col_reg) : (w_eff - EW'(1));
        sy = (row_reg < h_eff) ? row_reg : (h_eff - HW'(1));
        sxh = sx >> 1;
        syh = sy >> 1;
        oxf = (sxh < nw) ? sxh : (nw - EW'(1));
        oyf = (syh < nh) ? syh : (nh - HW'(1));
        ox = AW'(oxf);
        w_last = (sx == w_eff - EW'(1));
        h_last = (sy == h_eff - HW'(1));
        first_col = !sx[0] && (sxh < nw);
        last_col = w_last || (sx[0] && (sxh < nw - EW'(1)));
        last_row = h_last || (sy[0] && (syh < nh - HW'(1)));
        if (w_eff == EW'(1))
            gw = 2'd1;
        else if (oxf == nw - EW'(1))
            gw = 2'(w_eff - (oxf << 1));
        else
            gw = 2'd2;
        if (h_eff == HW'(1))
            gh = 2'd1;
        else if (oyf == nh - HW'(1))
            gh = 2'(h_eff - (oyf << 1));
        else
            gh = 2'd2;
        n_cnt = NW_W'(gw) * NW_W'(gh);
    end

    assign accept = texel_valid && (state_reg == F_IDLE);
    assign texel_stall = (state_reg != F_IDLE);
    assign proceed = !emit_reg || !q_full;

    assign wt = cfg.alpha_weighted ? texel.alpha : 8'd1;
    assign bytes[0] = texel.red;
    assign bytes[1] = texel.green;
    assign bytes[2] = texel.blue;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            val[k] = cfg.srgb_mode ? dec_lut[bytes[k]] : LINEAR_BITS'(bytes[k]);
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        win_next = win_reg;
        if (w_last)
        begin
            col_next = '0;
            if (h_last)
            begin
                row_next = '0;
                win_next = 2'd0;
            end
            else
            begin
                row_next = sy + HW'(1);
                win_next = last_row ? 2'd0 : (win_reg + 2'd1);
            end
        end
        else
        begin
            col_next = PW'(sx + EW'(1));
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                    state_next = F_ACC;
            end
            F_ACC:
            begin
                if (proceed)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg <= '0;
            row_reg <= '0;
            win_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (restart)
            begin
                col_reg <= '0;
                row_reg <= '0;
                win_reg <= 2'd0;
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 3; k++)
            begin
                ch_reg[k] <= CH_W'(val[k]) * CH_W'(wt);
            end
            wt_reg <= wt;
            alpha_reg <= texel.alpha;
            clear_reg <= (win_reg == 2'd0) && first_col;
            emit_reg <= last_col && last_row;
            n_reg <= n_cnt;
            last_reg <= w_last && h_last;
            ox_reg <= ox;
        end
    end

    assign ram_raddr = (state_reg == F_IDLE) ? ox : ox_reg;
    assign ram_we = (state_reg == F_ACC) && proceed;
    assign {old_sum[0], old_sum[1], old_sum[2], old_ws, old_as} = ram_rdata;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            new_sum[k] = (clear_reg ? '0 : old_sum[k]) + SUM_W'(ch_reg[k]);
        end
        new_ws = (clear_reg ? '0 : old_ws) + SW'(wt_reg);
        new_as = (clear_reg ? '0 : old_as) + SW'(alpha_reg);
    end

    assign ram_wdata = {new_sum[0], new_sum[1], new_sum[2], new_ws, new_as};
    assign q_push = (state_reg == F_ACC) && emit_reg && !q_full;
    assign q_data = {new_sum[0], new_sum[1], new_sum[2], new_ws, new_as, n_reg, last_reg};

    mbds_ram #(
        .WIDTH(RAM_W),
        .DEPTH(HALF)
    ) u_row_sums (
        .clk(clk),
        .we(ram_we),
        .waddr(ox_reg),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

endmodule

/* hdl/mbds_back.sv */
module mbds_back #(
    parameter int LINEAR_BITS = 16,
    parameter int ENCODE_INDEX_BITS = 12
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  srgb_mode,
    input  logic                  q_empty,
    output logic                  q_pop,
    input  logic [3*(LINEAR_BITS+12)+2*mbds_pkg::SUM_SMALL_W+mbds_pkg::COUNT_W:0] q_data,
    output logic                  mip_valid,
    input  logic                  mip_stall,
    output mbds_pkg::mip_texel_t  mip
);

    localparam int SUM_W = LINEAR_BITS + 12;
    localparam int SW = mbds_pkg::SUM_SMALL_W;
    localparam int NW_W = mbds_pkg::COUNT_W;
    localparam int QW = LINEAR_BITS + 1;
    localparam int DIVW = LINEAR_BITS + 14;
    localparam int CNT_W = $clog2(QW + 1);
    localparam int E = ENCODE_INDEX_BITS;
    localparam logic [QW-1:0] LIN_MAX = QW'((1 << LINEAR_BITS) - 1);
    localparam logic [QW-1:0] BYTE_MAX = QW'(255);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV = 2'd1;
    localparam logic [1:0] B_ENC = 2'd2;
    localparam logic [1:0] B_OUT = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [1:0]       step_reg;

    logic [DIVW-1:0]  rem_reg [4];
    logic [DIVW-1:0]  dsh_reg [4];
    logic [QW-1:0]    q_reg [4];
    logic             zero_reg;
    logic             last_reg;
    logic [7:0]       enc_reg [3];

    logic [SUM_W-1:0] e_sum [3];
    logic [SW-1:0]    e_ws;
    logic [SW-1:0]    e_as;
    logic [NW_W-1:0]  e_n;
    logic             e_last;

    logic [DIVW-1:0]  load_rem [4];
    logic [DIVW-1:0]  load_dsh [4];
    logic [E-1:0]     idx [3];
    logic [7:0]       lin [3];
    logic [7:0]       colour [3];
    logic [1:0]       step_sel;
    logic [7:0]       rom_data;
    logic             div_done;

    assign {e_sum[0], e_sum[1], e_sum[2], e_ws, e_as, e_n, e_last} = q_data;
    assign q_pop = (state_reg == B_IDLE) && !q_empty;
    assign div_done = (cnt_reg == CNT_W'(QW - 1));

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            load_rem[k] = DIVW'({e_sum[k], 1'b0}) + DIVW'(e_ws);
            load_dsh[k] = DIVW'({e_ws, 1'b0}) << (QW - 1);
        end
        load_rem[3] = DIVW'({e_as, 1'b0}) + DIVW'(e_n);
        load_dsh[3] = DIVW'({e_n, 1'b0}) << (QW - 1);
    end

    always_comb
    begin
        logic [QW-1:0] qc;
        logic [LINEAR_BITS+E-1:0] wide;
        for (int k = 0; k < 3; k++)
        begin
            qc = (q_reg[k] > LIN_MAX) ? LIN_MAX : q_reg[k];
            wide = {qc[LINEAR_BITS-1:0], {E{1'b0}}};
            idx[k] = wide[LINEAR_BITS+E-1:LINEAR_BITS];
            lin[k] = (q_reg[k] > BYTE_MAX) ? 8'hFF : q_reg[k][7:0];
            if (zero_reg)
                colour[k] = 8'd0;
            else if (srgb_mode)
                colour[k] = enc_reg[k];
            else
                colour[k] = lin[k];
        end
    end

    assign step_sel = (step_reg == 2'd3) ? 2'd0 : step_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                    state_next = B_DIV;
            end
            B_DIV:
            begin
                if (div_done)
                    state_next = B_ENC;
            end
            B_ENC:
            begin
                if (step_reg == 2'd3)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (!mip_stall)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg <= '0;
            step_reg <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_IDLE)
                cnt_reg <= '0;
            else if (state_reg == B_DIV)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (state_reg == B_ENC)
                step_reg <= step_reg + 2'd1;
            else
                step_reg <= 2'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            for (int k = 0; k < 4; k++)
            begin
                rem_reg[k] <= load_rem[k];
                dsh_reg[k] <= load_dsh[k];
                q_reg[k] <= '0;
            end
            zero_reg <= (e_ws == '0);
            last_reg <= e_last;
        end
        else if (state_reg == B_DIV)
        begin
            for (int k = 0; k < 4; k++)
            begin
                if (rem_reg[k] >= dsh_reg[k])
                begin
                    rem_reg[k] <= rem_reg[k] - dsh_reg[k];
                    q_reg[k] <= {q_reg[k][QW-2:0], 1'b1};
                end
                else
                begin
                    q_reg[k] <= {q_reg[k][QW-2:0], 1'b0};
                end
                dsh_reg[k] <= dsh_reg[k] >> 1;
            end
        end
        if ((state_reg == B_ENC) && (step_reg != 2'd0))
        begin
            enc_reg[step_reg - 2'd1] <= rom_data;
        end
    end

    assign mip_valid = (state_reg == B_OUT);
    assign mip.out_red = colour[0];
    assign mip.out_green = colour[1];
    assign mip.out_blue = colour[2];
    assign mip.out_alpha = (q_reg[3] > BYTE_MAX) ? 8'hFF : q_reg[3][7:0];
    assign mip.last_texel = last_reg;

    mbds_enc_rom #(
        .ENCODE_INDEX_BITS(ENCODE_INDEX_BITS)
    ) u_enc_rom (
        .clk(clk),
        .addr(idx[step_sel]),
        .data(rom_data)
    );

endmodule

/* hdl/mip_box_downsample_srgb_top.sv */
// Channel   Direction  Handshake               Payload
// texel     in         texel_valid/texel_stall mbds_pkg::texel_t (red, green, blue, alpha)
// mip       out        mip_valid/mip_stall     mbds_pkg::mip_texel_t (out_*, last_texel)
// cfg       in         cfg_we                  cfg_index selects register, cfg_data value
//
// Front takes one source texel at a time: row-sum memory read, then add and write back.
// Back takes a queue entry, runs the shift-subtract dividers, reads the encode table
// and holds the output register until it is taken, then takes the next entry.
// A two-entry queue between them absorbs output stalls; the front stalls when it is full.
// Reset clears positions and handshake state; the row-sum memory needs no clearing pass.
module mip_box_downsample_srgb_top #(
    parameter int MAX_SRC_WIDTH = 4096,
    parameter int LINEAR_BITS = 16,
    parameter int ENCODE_INDEX_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  texel_valid,
    output logic                                  texel_stall,
    input  mbds_pkg::texel_t                      texel,
    output logic                                  mip_valid,
    input  logic                                  mip_stall,
    output mbds_pkg::mip_texel_t                  mip,
    input  logic                                  cfg_we,
    input  logic [mbds_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [mbds_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SUM_W = LINEAR_BITS + 12;
    localparam int ENTRY_W = 3 * SUM_W + 2 * mbds_pkg::SUM_SMALL_W + mbds_pkg::COUNT_W + 1;

    mbds_pkg::cfg_t     cfg_reg;
    logic               restart;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    logic [ENTRY_W-1:0] q_push_data;
    logic [ENTRY_W-1:0] q_pop_data;

    assign restart = cfg_we && ((cfg_index == mbds_pkg::CFG_SRC_WIDTH) ||
                                (cfg_index == mbds_pkg::CFG_SRC_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_width <= mbds_pkg::WIDTH_REG_W'(1);
            cfg_reg.src_height <= mbds_pkg::HEIGHT_REG_W'(1);
            cfg_reg.srgb_mode <= 1'b0;
            cfg_reg.alpha_weighted <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                mbds_pkg::CFG_SRC_WIDTH:
                    cfg_reg.src_width <= cfg_data[mbds_pkg::WIDTH_REG_W-1:0];
                mbds_pkg::CFG_SRC_HEIGHT:
                    cfg_reg.src_height <= cfg_data;
                mbds_pkg::CFG_SRGB_MODE:
                    cfg_reg.srgb_mode <= cfg_data[0];
                mbds_pkg::CFG_ALPHA_WEIGHTED:
                    cfg_reg.alpha_weighted <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    mbds_front #(
        .MAX_SRC_WIDTH(MAX_SRC_WIDTH),
        .LINEAR_BITS(LINEAR_BITS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .restart(restart),
        .texel_valid(texel_valid),
        .texel_stall(texel_stall),
        .texel(texel),
        .q_push(q_push),
        .q_data(q_push_data),
        .q_full(q_full)
    );

    mbds_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(q_push),
        .push_data(q_push_data),
        .pop(q_pop),
        .pop_data(q_pop_data),
        .full(q_full),
        .empty(q_empty)
    );

    mbds_back #(
        .LINEAR_BITS(LINEAR_BITS),
        .ENCODE_INDEX_BITS(ENCODE_INDEX_BITS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .srgb_mode(cfg_reg.srgb_mode),
        .q_empty(q_empty),
        .q_pop(q_pop),
        .q_data(q_pop_data),
        .mip_valid(mip_valid),
        .mip_stall(mip_stall),
        .mip(mip)
    );

endmodule

/* tb/tb_mip_box_downsample_srgb_top.sv */
module tb_mip_box_downsample_srgb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ROW_SLOTS = 2048;
    localparam int MAX_W = 4096;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1000000;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    logic                 clk;
    logic                 rst_n;
    logic                 texel_valid;
    logic                 texel_stall;
    mbds_pkg::texel_t     texel;
    logic                 mip_valid;
    logic                 mip_stall;
    mbds_pkg::mip_texel_t mip;
    logic                 cfg_we;
    logic [mbds_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [mbds_pkg::CFG_DATA_W-1:0]  cfg_data;

    mip_box_downsample_srgb_top u_top (
        .clk(clk),
        .rst_n(rst_n),
        .texel_valid(texel_valid),
        .texel_stall(texel_stall),
        .texel(texel),
        .mip_valid(mip_valid),
        .mip_stall(mip_stall),
        .mip(mip),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // shadow configuration and row sums
    int unsigned width_reg;
    int unsigned height_reg;
    bit          srgb_on;
    bit          weight_on;
    longint unsigned red_acc [ROW_SLOTS];
    longint unsigned green_acc [ROW_SLOTS];
    longint unsigned blue_acc [ROW_SLOTS];
    longint unsigned weight_acc [ROW_SLOTS];
    longint unsigned alpha_acc [ROW_SLOTS];
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned rows_in_group;

    longint unsigned to_linear [256];
    bit [7:0]        to_srgb [4096];

    mbds_pkg::mip_texel_t pending_mips [$];
    int  errors;
    int  cycles;
    bit  idle_in;
    bit  idle_out;
    int  out_wait;
    int  holdoff;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic longint unsigned q30_pow(longint unsigned r, int n);
        longint unsigned acc;
        acc = Q30_ONE;
        for (int i = 0; i < n; i++)
            acc = (acc * r) >> 30;
        return acc;
    endfunction

    function automatic longint unsigned q30_root(longint unsigned v, int n);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        lo = 0;
        hi = Q30_ONE;
        while (lo < hi)
        begin
            mid = lo + (hi - lo + 1) / 2;
            if (q30_pow(mid, n) <= v)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo;
    endfunction

    function automatic void build_srgb_tables();
        longint unsigned t;
        longint unsigned v;
        longint unsigned lin;
        longint unsigned r;
        longint unsigned x;
        longint unsigned c;
        longint unsigned p;
        longint unsigned num;
        longint unsigned off;
        for (longint unsigned b = 0; b < 256; b++)
        begin
            if (b <= 10)
                r = (((b * 20) << 16) + 32946) / 65892;
            else
            begin
                t = ((1000 * b + 14025) << 30) / 269025;
                v = (t * t) >> 30;
                lin = (v * q30_root(v, 5)) >> 30;
                r = (lin + (64'd1 << 13)) >> 14;
            end
            to_linear[b] = (r > 65535) ? 65535 : r;
        end
        for (longint unsigned i = 0; i < 4096; i++)
        begin
            x = (2 * i + 1) << 17;
            if (x * 10000000 <= 31308 * Q30_ONE)
                r = (x * 32946 + 5 * Q30_ONE) / (10 * Q30_ONE);
            else
            begin
                c = q30_root(x, 3);
                p = (c * q30_root(c, 4)) >> 30;
                num = 269025 * p;
                off = 14025 * Q30_ONE;
                r = (num <= off) ? 0 : (num - off + 500 * Q30_ONE) / (1000 * Q30_ONE);
            end
            to_srgb[i] = (r > 255) ? 8'd255 : r[7:0];
        end
    endfunction

    function automatic bit [7:0] average_colour(longint unsigned sum, longint unsigned wsum);
        longint unsigned avg;
        if (wsum == 0)
            return 8'd0;
        avg = (2 * sum + wsum) / (2 * wsum);
        if (!srgb_on)
            return (avg > 255) ? 8'd255 : avg[7:0];
        if (avg > 65535)
            avg = 65535;
        return to_srgb[avg >> 4];
    endfunction

    function automatic void predict_mip(mbds_pkg::texel_t t);
        int unsigned w;
        int unsigned h;
        int unsigned nw;
        int unsigned nh;
        int unsigned sx;
        int unsigned sy;
        int unsigned ox;
        int unsigned oy;
        bit first_col;
        bit last_col;
        bit last_row;
        longint unsigned wt;
        longint unsigned cr;
        longint unsigned cg;
        longint unsigned cb;
        longint unsigned gw;
        longint unsigned gh;
        longint unsigned cnt;
        longint unsigned av;
        mbds_pkg::mip_texel_t m;
        w = (width_reg == 0) ? 1 : ((width_reg > MAX_W) ? MAX_W : width_reg);
        h = (height_reg == 0) ? 1 : height_reg;
        nw = (w / 2 != 0) ? w / 2 : 1;
        nh = (h / 2 != 0) ? h / 2 : 1;
        sx = (col_pos < w) ? col_pos : w - 1;
        sy = (row_pos < h) ? row_pos : h - 1;
        ox = (sx / 2 < nw) ? sx / 2 : nw - 1;
        oy = (sy / 2 < nh) ? sy / 2 : nh - 1;
        if (ox >= ROW_SLOTS)
            ox = ROW_SLOTS - 1;
        first_col = (sx % 2 == 0) && (sx / 2 < nw);
        last_col = (sx == w - 1) || ((sx % 2 == 1) && (sx / 2 < nw - 1));
        last_row = (sy == h - 1) || ((sy % 2 == 1) && (sy / 2 < nh - 1));
        wt = weight_on ? t.alpha : 1;
        cr = (srgb_on ? to_linear[t.red] : t.red) * wt;
        cg = (srgb_on ? to_linear[t.green] : t.green) * wt;
        cb = (srgb_on ? to_linear[t.blue] : t.blue) * wt;
        if (rows_in_group == 0 && first_col)
        begin
            red_acc[ox] = cr;
            green_acc[ox] = cg;
            blue_acc[ox] = cb;
            weight_acc[ox] = wt;
            alpha_acc[ox] = t.alpha;
        end
        else
        begin
            red_acc[ox] += cr;
            green_acc[ox] += cg;
            blue_acc[ox] += cb;
            weight_acc[ox] += wt;
            alpha_acc[ox] += t.alpha;
        end
        if (last_col && last_row)
        begin
            gw = (w == 1) ? 1 : ((ox == nw - 1) ? w - 2 * ox : 2);
            gh = (h == 1) ? 1 : ((oy == nh - 1) ? h - 2 * oy : 2);
            cnt = gw * gh;
            av = (2 * alpha_acc[ox] + cnt) / (2 * cnt);
            m.out_red = average_colour(red_acc[ox], weight_acc[ox]);
            m.out_green = average_colour(green_acc[ox], weight_acc[ox]);
            m.out_blue = average_colour(blue_acc[ox], weight_acc[ox]);
            m.out_alpha = (av > 255) ? 8'd255 : av[7:0];
            m.last_texel = (sx == w - 1) && (sy == h - 1);
            pending_mips = {pending_mips, m};
        end
        if (sx == w - 1)
        begin
            col_pos = 0;
            if (sy == h - 1)
            begin
                row_pos = 0;
                rows_in_group = 0;
            end
            else
            begin
                row_pos = sy + 1;
                rows_in_group = last_row ? 0 : ((rows_in_group + 1) % 4);
            end
        end
        else
            col_pos = sx + 1;
    endfunction

    always @(posedge clk)
    begin
        mbds_pkg::mip_texel_t want;
        if (rst_n && mip_valid && !mip_stall)
        begin
            out_wait = idle_out ? $urandom_range(0, 8) : 0;
            if (pending_mips.size() == 0)
            begin
                $display("%0t: unexpected output texel %h", $time, mip);
                errors++;
            end
            else
            begin
                want = pending_mips.pop_front();
                if (mip.out_red !== want.out_red)
                begin
                    $display("%0t: out_red expected %0d actual %0d", $time, want.out_red,
                        mip.out_red);
                    errors++;
                end
                if (mip.out_green !== want.out_green)
                begin
                    $display("%0t: out_green expected %0d actual %0d", $time, want.out_green,
                        mip.out_green);
                    errors++;
                end
                if (mip.out_blue !== want.out_blue)
                begin
                    $display("%0t: out_blue expected %0d actual %0d", $time, want.out_blue,
                        mip.out_blue);
                    errors++;
                end
                if (mip.out_alpha !== want.out_alpha)
                begin
                    $display("%0t: out_alpha expected %0d actual %0d", $time, want.out_alpha,
                        mip.out_alpha);
                    errors++;
                end
                if (mip.last_texel !== want.last_texel)
                begin
                    $display("%0t: last_texel expected %0d actual %0d", $time,
                        want.last_texel, mip.last_texel);
                    errors++;
                end
            end
        end
    end

    // receiver stall: long hold-off first, then per-transaction waits
    always @(negedge clk)
    begin
        if (holdoff > 0)
        begin
            mip_stall <= 1'b1;
            holdoff <= holdoff - 1;
        end
        else if (out_wait > 0)
        begin
            mip_stall <= 1'b1;
            out_wait <= out_wait - 1;
        end
        else
            mip_stall <= 1'b0;
    end

    task automatic send_texel(mbds_pkg::texel_t t);
        int gap;
        gap = idle_in ? $urandom_range(0, 8) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            texel_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        texel_valid <= 1'b1;
        texel <= t;
        do
            @(posedge clk);
        while (texel_stall);
        predict_mip(t);
    endtask

    task automatic drain();
        @(negedge clk);
        texel_valid <= 1'b0;
        while (pending_mips.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [mbds_pkg::CFG_INDEX_W-1:0] idx, int unsigned value);
        drain();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[mbds_pkg::CFG_DATA_W-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            mbds_pkg::CFG_SRC_WIDTH, mbds_pkg::CFG_SRC_HEIGHT:
            begin
                if (idx == mbds_pkg::CFG_SRC_WIDTH)
                    width_reg = value & 16'h1FFF;
                else
                    height_reg = value & 16'hFFFF;
                col_pos = 0;
                row_pos = 0;
                rows_in_group = 0;
            end
            mbds_pkg::CFG_SRGB_MODE: srgb_on = value[0];
            default: weight_on = value[0];
        endcase
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, bit srgb, bit wtd);
        write_reg(mbds_pkg::CFG_SRC_WIDTH, w);
        write_reg(mbds_pkg::CFG_SRC_HEIGHT, h);
        write_reg(mbds_pkg::CFG_SRGB_MODE, srgb);
        write_reg(mbds_pkg::CFG_ALPHA_WEIGHTED, wtd);
    endtask

    function automatic mbds_pkg::texel_t random_texel();
        mbds_pkg::texel_t t;
        t = $urandom;
        case ($urandom_range(0, 5))
            0: t.alpha = 8'd0;
            1: t.alpha = 8'd255;
            default: ;
        endcase
        return t;
    endfunction

    task automatic test_extremes();
        set_geometry(4, 4, 0, 1);
        send_texel(32'hFFFF_FFFF);
        send_texel(32'h0000_0000);
        send_texel(32'hFF00_FF00);
        send_texel(32'h00FF_00FF);
        send_texel(32'hFFFF_FF00);
        send_texel(32'h0000_0000);
        send_texel(32'h8080_80FF);
        send_texel(32'h7F7F_7F01);
        for (int i = 0; i < 8; i++)
            send_texel(i[0] ? 32'hFFFF_FF00 : 32'h0101_0100);
        write_reg(mbds_pkg::CFG_SRGB_MODE, 1);
        for (int i = 0; i < 16; i++)
            send_texel(i[0] ? 32'hFFFF_FFFF : 32'h0A0B_0C80);
    endtask

    task automatic test_odd_and_unit_sizes();
        set_geometry(3, 3, 1, 0);
        for (int i = 0; i < 9; i++)
            send_texel(random_texel());
        set_geometry(1, 1, 0, 0);
        send_texel(32'h1234_5678);
        set_geometry(0, 0, 1, 1);
        send_texel(32'hFEDC_BA98);
        send_texel(32'h0000_00FF);
        set_geometry(5, 1, 0, 1);
        for (int i = 0; i < 5; i++)
            send_texel(random_texel());
        set_geometry(1, 7, 1, 1);
        for (int i = 0; i < 7; i++)
            send_texel(random_texel());
    endtask

    task automatic test_mode_change_in_box();
        set_geometry(2, 2, 0, 0);
        send_texel(32'hC864_32FF);
        send_texel(32'h1020_3040);
        write_reg(mbds_pkg::CFG_SRGB_MODE, 1);
        write_reg(mbds_pkg::CFG_ALPHA_WEIGHTED, 1);
        send_texel(32'h8899_AA10);
        write_reg(mbds_pkg::CFG_SRGB_MODE, 0);
        send_texel(32'hFF00_7F80);
    endtask

    task automatic test_geometry_restart();
        set_geometry(6, 65535, 1, 0);
        for (int i = 0; i < 20; i++)
            send_texel(random_texel());
        write_reg(mbds_pkg::CFG_SRC_WIDTH, 4);
        write_reg(mbds_pkg::CFG_SRC_HEIGHT, 2);
        for (int i = 0; i < 8; i++)
            send_texel(random_texel());
    endtask

    task automatic test_full_width_row();
        idle_in = 0;
        idle_out = 0;
        set_geometry(8191, 1, 1, 1);
        for (int i = 0; i < 128; i++)
            send_texel(random_texel());
        idle_in = 1;
        idle_out = 1;
    endtask

    task automatic test_backpressure();
        set_geometry(8, 4, 0, 1);
        @(negedge clk);
        holdoff = 600;
        for (int i = 0; i < 64; i++)
            send_texel(random_texel());
        drain();
        for (int i = 0; i < 32; i++)
        begin
            send_texel(random_texel());
            if (i == 13)
                drain();
        end
    endtask

    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int sent;
        sent = 0;
        while (sent < 1450)
        begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
            set_geometry(w, h, $urandom_range(0, 1), $urandom_range(0, 1));
            idle_in = $urandom_range(0, 3) != 0;
            idle_out = $urandom_range(0, 3) != 0;
            repeat ($urandom_range(1, 3))
            begin
                for (int i = 0; i < w * h; i++)
                    send_texel(random_texel());
                sent += w * h;
            end
        end
        idle_in = 1;
        idle_out = 1;
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        holdoff = 0;
        out_wait = 0;
        idle_in = 1;
        idle_out = 1;
        rst_n = 1'b0;
        texel_valid = 1'b0;
        texel = '0;
        mip_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = mbds_pkg::CFG_SRC_WIDTH;
        cfg_data = '0;
        width_reg = 1;
        height_reg = 1;
        srgb_on = 0;
        weight_on = 0;
        col_pos = 0;
        row_pos = 0;
        rows_in_group = 0;
        build_srgb_tables();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_odd_and_unit_sizes();
        test_mode_change_in_box();
        test_geometry_restart();
        test_backpressure();
        test_full_width_row();
        test_random_frames();
        drain();

        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
